// File: rtl/assert_macros.svh
// Assertion macros used by the RTL of the IMU frame parser.
// Each macro expects signals clk and arst_n in the scope where it is used.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property checked on every rising edge, switched off while reset is held.
`define IMURVC_ASSERT(lbl, prop) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (prop)) \
		else $error("imu_rvc_frame_parser: assertion failed");

// Antecedent on one edge, consequent on the next.
`define IMURVC_ASSERT_NEXT(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("imu_rvc_frame_parser: assertion failed");

`endif

// File: rtl/imurvc_pkg.sv
// Package for the IMU RVC frame parser: field widths, header byte and
// decode constants. No dependencies.
`default_nettype none

package imurvc_pkg;

	localparam int unsigned BYTE_W       = 8;
	localparam int unsigned ANGLE_W      = 16;
	localparam int unsigned TENTHS_W     = 12;
	localparam int unsigned POS_W        = 5;

	localparam logic [BYTE_W-1:0] HDR_BYTE = 8'hAA;

	// Angle bytes sit at frame positions 3..8 (yaw, pitch, roll, little-endian)
	localparam int unsigned ANGLE_BYTES  = 6;
	localparam int unsigned ANGLE_IDX_W  = 3;
	localparam logic [POS_W-1:0] ANGLE_FIRST_POS = 5'd3;
	localparam logic [POS_W-1:0] ANGLE_LAST_POS  = 5'd8;

	// x / 10 = (x * 52429) >> 19, exact for x up to 32768
	localparam logic [ANGLE_W-1:0] DIV10_MUL   = 16'd52429;
	localparam int unsigned        DIV10_SHIFT = 19;

	localparam logic [TENTHS_W-1:0] YAW_WRAP = 12'd3600;

endpackage

`default_nettype wire

// File: rtl/imurvc_byte_if.sv
// Request channel carrying one received serial byte.
// Depends on imurvc_pkg for the byte width.
`default_nettype none

interface imurvc_byte_if;
	logic                             valid;
	logic                             ready;
	logic [imurvc_pkg::BYTE_W-1:0]    rx_byte;

	modport source (output valid, output rx_byte, input ready);
	modport sink   (input valid, input rx_byte, output ready);
endinterface

`default_nettype wire

// File: rtl/imurvc_res_if.sv
// Result channel: checksum verdict, the held angle values of the last good
// frame, the yaw rate sum and a seen flag. Depends on imurvc_pkg for field widths.
`default_nettype none

interface imurvc_res_if;
	logic                                valid;
	logic                                ready;
	logic                                frame_ok;
	logic [imurvc_pkg::TENTHS_W-1:0]     yaw_tenths;
	logic signed [imurvc_pkg::ANGLE_W-1:0] yaw_hundredths;
	logic signed [imurvc_pkg::ANGLE_W-1:0] pitch_out;
	logic signed [imurvc_pkg::ANGLE_W-1:0] roll_out;
	logic signed [imurvc_pkg::ANGLE_W-1:0] yaw_rate_sum;
	logic                                ever_valid;

	modport source (output valid, output frame_ok, output yaw_tenths,
		output yaw_hundredths, output pitch_out, output roll_out,
		output yaw_rate_sum, output ever_valid, input ready);
	modport sink (input valid, input frame_ok, input yaw_tenths,
		input yaw_hundredths, input pitch_out, input roll_out,
		input yaw_rate_sum, input ever_valid, output ready);
endinterface

`default_nettype wire

// File: rtl/imu_rvc_frame_parser.sv
// Flow: a byte is taken into the input register and is parsed from there; a checksum
// byte goes on once the result slot is free, and its verdict is then registered.
// Throughput: one byte per cycle; a waiting result stalls only a checksum byte.
// Reset (arst_n low, asynchronous): parser hunts the first header, held angles,
// rate accumulator, valid flag and swap setting clear; no clearing pass.
`default_nettype none
`include "assert_macros.svh"

module imu_rvc_frame_parser #(
	parameter int unsigned FRAME_DATA_BYTES = 18,
	parameter int unsigned RATE_WINDOW      = 20
) (
	input  wire logic          clk,
	input  wire logic          arst_n,
	input  wire logic          cfg_we,
	input  wire logic          cfg_wdata,
	imurvc_byte_if.sink        rx,
	imurvc_res_if.source       res
);

	localparam int unsigned RC_W  = $clog2(RATE_WINDOW + 1);
	localparam int unsigned BW    = imurvc_pkg::BYTE_W;
	localparam int unsigned AW    = imurvc_pkg::ANGLE_W;
	localparam int unsigned TW    = imurvc_pkg::TENTHS_W;
	localparam int unsigned PW    = imurvc_pkg::POS_W;

	localparam logic [1:0] PH_HUNT1 = 2'd0;
	localparam logic [1:0] PH_HUNT2 = 2'd1;
	localparam logic [1:0] PH_BODY  = 2'd2;
	localparam logic [1:0] PH_CSUM  = 2'd3;

	localparam logic [PW-1:0] LAST_POS = PW'(FRAME_DATA_BYTES);

	// input register
	logic          v_s1;
	logic [BW-1:0] b_s1;

	logic          swap_q;
	logic [1:0]    phase_q;
	logic [PW-1:0] pos_q;
	logic [BW-1:0] sum_q;
	logic [BW-1:0] ang_q [imurvc_pkg::ANGLE_BYTES];
	logic [TW-1:0] tenths_q;
	logic [AW-1:0] yaw_raw_q;
	logic [AW-1:0] pitch_q;
	logic [AW-1:0] roll_q;
	logic [AW-1:0] prev_yaw_q;
	logic [AW-1:0] acc_q;
	logic [RC_W-1:0] rate_cnt_q;
	logic          seen_q;
	logic          ok_q;
	logic          out_v_q;

	logic          s1_is_res;
	logic          s1_go;
	logic          good;
	logic [PW-1:0] pos_inc;
	logic [imurvc_pkg::ANGLE_IDX_W-1:0] ang_idx;
	logic          ang_wr;
	logic [AW-1:0] yaw;
	logic [AW-1:0] pitch;
	logic [AW-1:0] roll;
	logic          yaw_neg;
	logic [AW-1:0] yaw_mag;
	logic [2*AW-1:0] div_prod;
	logic [TW-1:0] quot;
	logic [TW-1:0] tenths_nxt;

	// a checksum byte waits only while an untaken result occupies the slot
	assign s1_is_res = (phase_q == PH_CSUM);
	assign s1_go     = v_s1 && (!s1_is_res || !out_v_q || res.ready);
	assign rx.ready  = !v_s1 || s1_go;
	assign good      = (sum_q == b_s1);

	assign pos_inc = pos_q + PW'(1);
	assign ang_wr  = (pos_q >= imurvc_pkg::ANGLE_FIRST_POS) &&
		(pos_q <= imurvc_pkg::ANGLE_LAST_POS);
	assign ang_idx = imurvc_pkg::ANGLE_IDX_W'(pos_q - imurvc_pkg::ANGLE_FIRST_POS);

	assign yaw   = {ang_q[1], ang_q[0]};
	assign pitch = {ang_q[3], ang_q[2]};
	assign roll  = {ang_q[5], ang_q[4]};

	// truncating divide by ten on the magnitude, then wrap negatives to 0..3599
	assign yaw_neg  = yaw[AW-1];
	assign yaw_mag  = yaw_neg ? (AW'(0) - yaw) : yaw;
	assign div_prod = yaw_mag * imurvc_pkg::DIV10_MUL;
	assign quot     = div_prod[imurvc_pkg::DIV10_SHIFT +: TW];
	always_comb begin
		if (!yaw_neg) begin
			tenths_nxt = quot;
		end else if (quot == TW'(0)) begin
			tenths_nxt = TW'(0);
		end else begin
			tenths_nxt = imurvc_pkg::YAW_WRAP - quot;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else if (rx.valid && rx.ready) begin
			v_s1 <= 1'b1;
		end else if (s1_go) begin
			v_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (rx.valid && rx.ready) begin
			b_s1 <= rx.rx_byte;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			swap_q <= 1'b0;
		end else if (cfg_we) begin
			swap_q <= cfg_wdata;
		end
	end

	always_ff @(posedge clk) begin
		if (s1_go && phase_q == PH_BODY && ang_wr) begin
			ang_q[ang_idx] <= b_s1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= PH_HUNT1;
			pos_q   <= '0;
			sum_q   <= '0;
		end else if (s1_go) begin
			unique case (phase_q)
				PH_HUNT1: begin
					if (b_s1 == imurvc_pkg::HDR_BYTE) begin
						pos_q   <= PW'(1);
						phase_q <= PH_HUNT2;
					end
				end
				PH_HUNT2: begin
					if (b_s1 == imurvc_pkg::HDR_BYTE) begin
						pos_q   <= PW'(2);
						sum_q   <= '0;
						phase_q <= PH_BODY;
					end else begin
						pos_q   <= '0;
						phase_q <= PH_HUNT1;
					end
				end
				PH_BODY: begin
					sum_q <= sum_q + b_s1;
					pos_q <= pos_inc;
					if (pos_inc >= LAST_POS) begin
						phase_q <= PH_CSUM;
					end
				end
				PH_CSUM: begin
					pos_q   <= '0;
					phase_q <= PH_HUNT1;
				end
			endcase
		end
	end

	// held values double as the result payload: they change only when a good
	// frame's result is loaded, when the slot is empty or the previous one is being taken
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tenths_q   <= '0;
			yaw_raw_q  <= '0;
			pitch_q    <= '0;
			roll_q     <= '0;
			prev_yaw_q <= '0;
			acc_q      <= '0;
			rate_cnt_q <= '0;
			seen_q     <= 1'b0;
		end else if (s1_go && s1_is_res && good) begin
			tenths_q  <= tenths_nxt;
			yaw_raw_q <= yaw;
			pitch_q   <= swap_q ? roll : pitch;
			roll_q    <= swap_q ? pitch : roll;
			seen_q    <= 1'b1;
			if (rate_cnt_q < RC_W'(RATE_WINDOW)) begin
				acc_q      <= acc_q + yaw - prev_yaw_q;
				rate_cnt_q <= rate_cnt_q + RC_W'(1);
				prev_yaw_q <= yaw;
			end else begin
				acc_q      <= '0;
				rate_cnt_q <= '0;
				prev_yaw_q <= '0;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_v_q <= 1'b0;
			ok_q    <= 1'b0;
		end else if (s1_go && s1_is_res) begin
			out_v_q <= 1'b1;
			ok_q    <= good;
		end else if (res.ready) begin
			out_v_q <= 1'b0;
		end
	end

	assign res.valid          = out_v_q;
	assign res.frame_ok       = ok_q;
	assign res.yaw_tenths     = tenths_q;
	assign res.yaw_hundredths = $signed(yaw_raw_q);
	assign res.pitch_out      = $signed(pitch_q);
	assign res.roll_out       = $signed(roll_q);
	assign res.yaw_rate_sum   = $signed(acc_q);
	assign res.ever_valid     = seen_q;

	`IMURVC_ASSERT(a_res_from_csum, $rose(out_v_q) |-> $past(phase_q) == PH_CSUM)
	`IMURVC_ASSERT(a_ok_sets_seen, (out_v_q && ok_q) |-> seen_q)
	`IMURVC_ASSERT(a_tenths_range, tenths_q < imurvc_pkg::YAW_WRAP)
	`IMURVC_ASSERT(a_rate_cnt_range, rate_cnt_q <= RC_W'(RATE_WINDOW))
	`IMURVC_ASSERT(a_body_pos, (phase_q == PH_BODY) |-> (pos_q >= PW'(2) && pos_q < LAST_POS))
	`IMURVC_ASSERT_NEXT(a_csum_returns, (s1_go && s1_is_res), (phase_q == PH_HUNT1 && out_v_q))

endmodule

`default_nettype wire
